[rtl/core/tsl_pkg.sv]
// tsl_pkg: transaction types, operation and status codes, and the
// controller/datapath command and status structs of the table step lookup.
// No dependencies.
`default_nettype none

package tsl_pkg;

   // operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SHAPE  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_UNDEFINED  = 3'd1;
   localparam logic [2:0] ST_NOT_1D     = 3'd2;
   localparam logic [2:0] ST_BAD_COLUMN = 3'd3;
   localparam logic [2:0] ST_NOT_INCR   = 3'd4;

   // how a decoded transaction continues
   localparam logic [1:0] CAT_IMMEDIATE = 2'd0;
   localparam logic [1:0] CAT_ONE_ROW   = 2'd1;
   localparam logic [1:0] CAT_SEARCH    = 2'd2;

   // element read selects
   localparam logic [2:0] RD_A1   = 3'd0;
   localparam logic [2:0] RD_A2   = 3'd1;
   localparam logic [2:0] RD_PREV = 3'd2;
   localparam logic [2:0] RD_NEXT = 3'd3;
   localparam logic [2:0] RD_UP   = 3'd4;
   localparam logic [2:0] RD_DOWN = 3'd5;
   localparam logic [2:0] RD_ONE  = 3'd6;

   // capture selects for the segment fetch
   localparam logic [1:0] CAP_A1   = 2'd0;
   localparam logic [1:0] CAP_A2   = 2'd1;
   localparam logic [1:0] CAP_PREV = 2'd2;
   localparam logic [1:0] CAP_NEXT = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         table_id;
      logic [6:0]         row;
      logic [3:0]         column;
      logic               one_dimensional;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] previous_value;
      logic signed [31:0] next_value;
      logic [5:0]         segment;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       cap_en;
      logic [1:0] cap_sel;
      logic       cap_one;
      logic       up_step;
      logic       down_step;
      logic       finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] category;
      logic       up_go;
      logic       up_hit;
      logic       down_go;
      logic       down_hit;
   } ctl_status_type;

endpackage

`default_nettype wire

[rtl/core/tsl_ram.sv]
// tsl_ram: generic simple dual port RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none

module tsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/core/tsl_ctrl.sv]
// tsl_ctrl: sequencer of the table step lookup; issues datapath commands
// and runs the up/down segment search. Depends on tsl_pkg.
`default_nettype none

module tsl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   output      logic                    rsp_strobe,
   input  wire tsl_pkg::ctl_status_type stat,
   output      tsl_pkg::ctl_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_UP_RD   = 4'd2;
   localparam logic [3:0] S_UP_CMP  = 4'd3;
   localparam logic [3:0] S_DN_RD   = 4'd4;
   localparam logic [3:0] S_DN_CMP  = 4'd5;
   localparam logic [3:0] S_FETCH   = 4'd6;
   localparam logic [3:0] S_ONE_RD  = 4'd7;
   localparam logic [3:0] S_ONE_CAP = 4'd8;
   localparam logic [3:0] S_FINISH  = 4'd9;
   localparam logic [3:0] S_RESP    = 4'd10;

   localparam logic [2:0] FETCH_LAST = 3'd4;

   logic [3:0] state_ff, state_in;
   logic [2:0] fetch_ff, fetch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fetch_ff <= '0;
      end else begin
         state_ff <= state_in;
         fetch_ff <= fetch_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fetch_in = fetch_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            unique case (stat.category)
               tsl_pkg::CAT_ONE_ROW: state_in = S_ONE_RD;
               tsl_pkg::CAT_SEARCH:  state_in = S_UP_RD;
               default:              state_in = S_RESP;
            endcase
         end
         S_UP_RD: begin
            if (stat.up_go) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = tsl_pkg::RD_UP;
               state_in   = S_UP_CMP;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_UP_CMP: begin
            if (stat.up_hit) begin
               cmd.up_step = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (stat.down_go) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = tsl_pkg::RD_DOWN;
               state_in   = S_DN_CMP;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_DN_CMP: begin
            if (stat.down_hit) begin
               cmd.down_step = 1'b1;
               state_in      = S_DN_RD;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // four reads in a row, each captured in the cycle after its read
            unique case (fetch_ff)
               3'd0: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = tsl_pkg::RD_A1;
               end
               3'd1: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = tsl_pkg::RD_A2;
                  cmd.cap_en  = 1'b1;
                  cmd.cap_sel = tsl_pkg::CAP_A1;
               end
               3'd2: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = tsl_pkg::RD_PREV;
                  cmd.cap_en  = 1'b1;
                  cmd.cap_sel = tsl_pkg::CAP_A2;
               end
               3'd3: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = tsl_pkg::RD_NEXT;
                  cmd.cap_en  = 1'b1;
                  cmd.cap_sel = tsl_pkg::CAP_PREV;
               end
               default: begin
                  cmd.cap_en  = 1'b1;
                  cmd.cap_sel = tsl_pkg::CAP_NEXT;
               end
            endcase
            if (fetch_ff == FETCH_LAST) begin
               fetch_in = '0;
               state_in = S_FINISH;
            end else begin
               fetch_in = fetch_ff + 3'd1;
            end
         end
         S_ONE_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tsl_pkg::RD_ONE;
            state_in   = S_ONE_CAP;
         end
         S_ONE_CAP: begin
            cmd.cap_one = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

`default_nettype wire

[rtl/core/tsl_datapath.sv]
// tsl_datapath: table shape registers, element store, search segment and
// result register of the table step lookup. Depends on tsl_pkg, tsl_ram.
`default_nettype none

module tsl_datapath #(
   parameter int NUM_TABLES  = 4,
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tsl_pkg::req_type        req_item,
   input  wire tsl_pkg::ctl_cmd_type    cmd,
   output      tsl_pkg::ctl_status_type stat,
   output      tsl_pkg::rsp_type        rsp_item
);

   localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int SW    = $clog2(MAX_ROWS);
   localparam int DEPTH = NUM_TABLES * MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int VW    = VALUE_WIDTH;

   // per table shape and search hint
   logic [RW-1:0] row_count_ff [NUM_TABLES];
   logic [CW-1:0] col_count_ff [NUM_TABLES];
   logic          one_d_ff     [NUM_TABLES];
   logic          defined_ff   [NUM_TABLES];
   logic [SW-1:0] last_seg_ff  [NUM_TABLES];

   tsl_pkg::req_type item_ff;
   tsl_pkg::rsp_type rsp_ff, rsp_in;
   logic [SW-1:0]    iu_ff, iu_in;
   logic             one_ff;
   logic [VW-1:0]    a1_ff, a2_ff, prev_ff, next_ff;

   logic [TW-1:0] idx;
   logic          tid_ok;
   logic [31:0]   row_w, col_w, iu_w;
   logic [RW-1:0] nrows, top;
   logic [SW-1:0] hint;
   logic [VW-1:0] key, rdata, wdata;
   logic          write_ok, mem_we, mem_re;
   logic [AW-1:0] waddr, raddr;
   logic [RW-1:0] shape_rows;
   logic [CW-1:0] shape_cols;
   logic [1:0]    category;
   logic [2:0]    err_status;

   function automatic logic [AW-1:0] cell_addr(input logic [TW-1:0] t,
                                                input logic [31:0] r,
                                                input logic [31:0] c);
      logic [31:0] lin;
      lin = (32'(t) * 32'(MAX_ROWS) + r - 32'd1) * 32'(MAX_COLS) + c - 32'd1;
      return AW'(lin);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
   end

   assign idx    = TW'(item_ff.table_id);
   assign tid_ok = 32'(item_ff.table_id) < 32'(NUM_TABLES);
   assign row_w  = 32'(item_ff.row);
   assign col_w  = 32'(item_ff.column);
   assign iu_w   = 32'(iu_ff);
   assign nrows  = row_count_ff[idx];
   assign top    = nrows - RW'(1);
   assign hint   = last_seg_ff[idx];
   assign key    = VW'($unsigned(item_ff.value));
   assign wdata  = VW'($unsigned(item_ff.value));

   // shape clamps
   always_comb begin
      if (row_w == 32'd0) begin
         shape_rows = RW'(1);
      end else if (row_w > 32'(MAX_ROWS)) begin
         shape_rows = RW'(MAX_ROWS);
      end else begin
         shape_rows = RW'(row_w);
      end
      if (col_w == 32'd0) begin
         shape_cols = CW'(1);
      end else if (col_w > 32'(MAX_COLS)) begin
         shape_cols = CW'(MAX_COLS);
      end else begin
         shape_cols = CW'(col_w);
      end
   end

   // lookup checks, in priority order
   always_comb begin
      err_status = tsl_pkg::ST_OK;
      category   = tsl_pkg::CAT_IMMEDIATE;
      if (!tid_ok || !defined_ff[idx]) begin
         err_status = tsl_pkg::ST_UNDEFINED;
      end else if (!one_d_ff[idx]) begin
         err_status = tsl_pkg::ST_NOT_1D;
      end else if (col_w < 32'd2 || col_w > 32'(col_count_ff[idx])) begin
         err_status = tsl_pkg::ST_BAD_COLUMN;
      end else if (nrows <= RW'(1)) begin
         category = tsl_pkg::CAT_ONE_ROW;
      end else begin
         category = tsl_pkg::CAT_SEARCH;
      end
      if (item_ff.op != tsl_pkg::OP_LOOKUP) begin
         category = tsl_pkg::CAT_IMMEDIATE;
      end
   end

   assign write_ok = tid_ok && row_w >= 32'd1 && row_w <= 32'(MAX_ROWS) &&
                     col_w >= 32'd1 && col_w <= 32'(MAX_COLS);
   assign mem_we   = cmd.decode && item_ff.op == tsl_pkg::OP_WRITE && write_ok;
   assign waddr    = cell_addr(idx, row_w, col_w);
   assign mem_re   = cmd.rd_en;

   always_comb begin
      unique case (cmd.rd_sel)
         tsl_pkg::RD_A1:   raddr = cell_addr(idx, iu_w, 32'd1);
         tsl_pkg::RD_A2:   raddr = cell_addr(idx, iu_w + 32'd1, 32'd1);
         tsl_pkg::RD_PREV: raddr = cell_addr(idx, iu_w, col_w);
         tsl_pkg::RD_NEXT: raddr = cell_addr(idx, iu_w + 32'd1, col_w);
         tsl_pkg::RD_UP:   raddr = cell_addr(idx, iu_w + 32'd1, 32'd1);
         tsl_pkg::RD_DOWN: raddr = cell_addr(idx, iu_w, 32'd1);
         tsl_pkg::RD_ONE:  raddr = cell_addr(idx, 32'd1, col_w);
         default:          raddr = cell_addr(idx, 32'd1, 32'd1);
      endcase
   end

   tsl_ram #(
      .WIDTH(VW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (mem_we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (mem_re),
      .raddr(raddr),
      .rdata(rdata)
   );

   // search segment: starting point is the hint clamped into 1..top
   always_comb begin
      iu_in = iu_ff;
      if (cmd.decode) begin
         if (RW'(hint) > top) begin
            iu_in = SW'(top);
         end else if (hint == '0) begin
            iu_in = SW'(1);
         end else begin
            iu_in = hint;
         end
      end else if (cmd.up_step) begin
         iu_in = iu_ff + SW'(1);
      end else if (cmd.down_step) begin
         iu_in = iu_ff - SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      iu_ff <= iu_in;
      if (cmd.decode) begin
         one_ff <= (category == tsl_pkg::CAT_ONE_ROW);
      end
      if (cmd.cap_one) begin
         prev_ff <= rdata;
         next_ff <= rdata;
      end else if (cmd.cap_en) begin
         unique case (cmd.cap_sel)
            tsl_pkg::CAP_A1:   a1_ff   <= rdata;
            tsl_pkg::CAP_A2:   a2_ff   <= rdata;
            tsl_pkg::CAP_PREV: prev_ff <= rdata;
            default:           next_ff <= rdata;
         endcase
      end
   end

   assign stat.category = category;
   assign stat.up_go    = RW'(iu_ff) < top;
   assign stat.up_hit   = $signed(key) > $signed(rdata);
   assign stat.down_go  = iu_ff > SW'(1);
   assign stat.down_hit = $signed(key) < $signed(rdata);

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.decode) begin
         rsp_in.status         = tsl_pkg::ST_OK;
         rsp_in.previous_value = '0;
         rsp_in.next_value     = '0;
         rsp_in.segment        = 6'd1;
         unique case (item_ff.op)
            tsl_pkg::OP_WRITE: begin
               if (tid_ok) begin
                  rsp_in.segment = 6'(hint);
               end
            end
            tsl_pkg::OP_LOOKUP: rsp_in.status = err_status;
            default: ;
         endcase
      end else if (cmd.finish) begin
         if (one_ff) begin
            rsp_in.status         = tsl_pkg::ST_OK;
            rsp_in.previous_value = 32'(prev_ff);
            rsp_in.next_value     = 32'(next_ff);
            rsp_in.segment        = 6'd1;
         end else if (!($signed(a1_ff) < $signed(a2_ff))) begin
            rsp_in.status         = tsl_pkg::ST_NOT_INCR;
            rsp_in.previous_value = '0;
            rsp_in.next_value     = '0;
            rsp_in.segment        = 6'(iu_ff);
         end else begin
            rsp_in.status         = tsl_pkg::ST_OK;
            rsp_in.previous_value = 32'(prev_ff);
            rsp_in.next_value     = 32'(next_ff);
            rsp_in.segment        = 6'(iu_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_item = rsp_ff;

   // shape registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TABLES; t++) begin
            row_count_ff[t] <= RW'(1);
            col_count_ff[t] <= CW'(1);
            one_d_ff[t]     <= 1'b0;
            defined_ff[t]   <= 1'b0;
            last_seg_ff[t]  <= SW'(1);
         end
      end else begin
         if (cmd.decode && item_ff.op == tsl_pkg::OP_SHAPE && tid_ok) begin
            row_count_ff[idx] <= shape_rows;
            col_count_ff[idx] <= shape_cols;
            one_d_ff[idx]     <= item_ff.one_dimensional;
            defined_ff[idx]   <= 1'b1;
            last_seg_ff[idx]  <= SW'(1);
         end else if (cmd.finish && !one_ff) begin
            last_seg_ff[idx] <= iu_ff;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/table_step_lookup_core.sv]
// table_step_lookup_core: top level of the table step lookup.
// Depends on tsl_pkg, tsl_ctrl, tsl_datapath (and tsl_ram below it).
//
// Usage:
//  - Request channel: drive req_item and raise start; the transaction is
//    taken at a rising edge with start high and busy low. busy stays high
//    until the result has been shown.
//  - Result channel: rsp_item is valid for exactly one cycle, flagged by
//    rsp_strobe. The receiver cannot stall; it must take it in that cycle.
//  - Every transaction (write, shape, lookup, unused code) gives one result.
//  - Sequence: write, shape, unused code and lookup errors go from decode
//    straight to the result, and busy drops after the result is shown.
//  - A lookup in a one row table reads one element of row 1. A searching
//    lookup steps the segment up, then down, one element read and compare
//    per step on the registered read port of the element store, then
//    fetches both abscissas and both values of the found segment.
//  - Reset (synchronous, active high) clears all shapes: no table is
//    defined, every remembered segment is 1. The element store is not
//    cleared; an element must be written before a lookup reads it.
`default_nettype none

module table_step_lookup_core #(
   parameter int NUM_TABLES  = 4,
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire tsl_pkg::req_type req_item,
   output      logic             rsp_strobe,
   output      tsl_pkg::rsp_type rsp_item
);

   tsl_pkg::ctl_cmd_type    cmd;
   tsl_pkg::ctl_status_type stat;

   // sequencer: search loop and read/capture schedule
   tsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .stat      (stat),
      .cmd       (cmd)
   );

   // shape registers, element store, segment and result registers
   tsl_datapath #(
      .NUM_TABLES (NUM_TABLES),
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_item(req_item),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_item(rsp_item)
   );

endmodule

`default_nettype wire

[rtl/core/tsl_checker.sv]
// tsl_checker: port level checks of the table step lookup, bound to the
// top level. Depends on tsl_pkg, table_step_lookup_core.
`default_nettype none

module tsl_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire tsl_pkg::rsp_type rsp_item
);

   // a result only belongs to a transaction in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // the result strobe is one cycle wide
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held over two cycles");

   // error results carry zero values
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != tsl_pkg::ST_OK) |->
         (rsp_item.previous_value == '0 && rsp_item.next_value == '0))
      else $error("error result with nonzero values");

endmodule

bind table_step_lookup_core tsl_checker u_tsl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[test/tb_table_step_lookup_core.sv]
// tb_table_step_lookup_core: self-checking testbench of the table step lookup core.
// Drives write, shape and lookup transactions and checks every result against a
// built-in predictor. Depends on tsl_pkg and table_step_lookup_core.
`default_nettype none

module tb_table_step_lookup_core;

   localparam int NUM_TABLES   = 4;
   localparam int MAX_ROWS     = 64;
   localparam int MAX_COLS     = 8;
   localparam int STORE_DEPTH  = NUM_TABLES * MAX_ROWS * MAX_COLS;
   localparam int ITEM_TARGET  = 1850;
   localparam int IDLE_PERCENT = 11;
   localparam int PAUSE_EVERY  = 400;
   // the code that the block leaves unused: no state change, plain result
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             rsp_strobe;
   tsl_pkg::req_type req_item;
   tsl_pkg::rsp_type rsp_item;

   table_step_lookup_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Predictor state: a private copy of the tables. elem_written tracks which
   // cells hold data, so that no lookup is ever sent that reads an unwritten one.
   logic signed [31:0] elem_mem     [STORE_DEPTH];
   bit                 elem_written [STORE_DEPTH];
   int                 tbl_rows     [NUM_TABLES];
   int                 tbl_cols     [NUM_TABLES];
   bit                 tbl_one_d    [NUM_TABLES];
   bit                 tbl_defined  [NUM_TABLES];
   int                 hint_seg     [NUM_TABLES];

   tsl_pkg::rsp_type pending_results[$];   // expected results, oldest first
   int               fail_count;
   int               items_sent;
   bit               idle_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("table_step_lookup_core test failed");
      $finish;
   end

   function automatic int cell_index(input int t, input int r, input int c);
      return (t * MAX_ROWS + r - 1) * MAX_COLS + c - 1;
   endfunction

   // Works out the result of one transaction. With commit set the predictor
   // state is updated too; with it clear this is a dry run. unwritten flags any
   // element read that was never written.
   function automatic void predict_result(input tsl_pkg::req_type r, input bit commit,
                                          output tsl_pkg::rsp_type y,
                                          output bit unwritten);
      int                 t;
      int                 nrow;
      int                 ncol;
      int                 top;
      int                 seg;
      int                 idx;
      logic signed [31:0] x;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
      t = int'(r.table_id);
      nrow = int'(r.row);
      ncol = int'(r.column);
      x = r.value;
      y = '0;
      unwritten = 1'b0;
      case (r.op)
         tsl_pkg::OP_WRITE: begin
            if (commit && nrow >= 1 && nrow <= MAX_ROWS && ncol >= 1 && ncol <= MAX_COLS) begin
               idx = cell_index(t, nrow, ncol);
               elem_mem[idx] = x;
               elem_written[idx] = 1'b1;
            end
            y.segment = 6'(hint_seg[t]);
         end
         tsl_pkg::OP_SHAPE: begin
            if (commit) begin
               tbl_rows[t] = nrow < 1 ? 1 : (nrow > MAX_ROWS ? MAX_ROWS : nrow);
               tbl_cols[t] = ncol < 1 ? 1 : (ncol > MAX_COLS ? MAX_COLS : ncol);
               tbl_one_d[t] = r.one_dimensional;
               tbl_defined[t] = 1'b1;
               hint_seg[t] = 1;
            end
            y.segment = 6'd1;
         end
         tsl_pkg::OP_LOOKUP: begin
            y.segment = 6'd1;
            if (!tbl_defined[t]) begin
               y.status = tsl_pkg::ST_UNDEFINED;
            end else if (!tbl_one_d[t]) begin
               y.status = tsl_pkg::ST_NOT_1D;
            end else if (ncol < 2 || ncol > tbl_cols[t]) begin
               y.status = tsl_pkg::ST_BAD_COLUMN;
            end else if (tbl_rows[t] <= 1) begin
               // one row: both values come from row 1, hint untouched
               idx = cell_index(t, 1, ncol);
               unwritten = !elem_written[idx];
               y.previous_value = elem_mem[idx];
               y.next_value = elem_mem[idx];
            end else begin
               top = tbl_rows[t] - 1;
               seg = hint_seg[t];
               if (seg < 1) seg = 1;
               if (seg > top) seg = top;
               // step up while above the segment end, then down while below its start
               while (seg < top) begin
                  idx = cell_index(t, seg + 1, 1);
                  unwritten |= !elem_written[idx];
                  if (x > elem_mem[idx]) seg++;
                  else break;
               end
               while (seg > 1) begin
                  idx = cell_index(t, seg, 1);
                  unwritten |= !elem_written[idx];
                  if (x < elem_mem[idx]) seg--;
                  else break;
               end
               if (commit) hint_seg[t] = seg;
               y.segment = 6'(seg);
               unwritten |= !elem_written[cell_index(t, seg, 1)];
               unwritten |= !elem_written[cell_index(t, seg + 1, 1)];
               a1 = elem_mem[cell_index(t, seg, 1)];
               a2 = elem_mem[cell_index(t, seg + 1, 1)];
               if (a1 >= a2) begin
                  y.status = tsl_pkg::ST_NOT_INCR;
               end else begin
                  unwritten |= !elem_written[cell_index(t, seg, ncol)];
                  unwritten |= !elem_written[cell_index(t, seg + 1, ncol)];
                  y.previous_value = elem_mem[cell_index(t, seg, ncol)];
                  y.next_value = elem_mem[cell_index(t, seg + 1, ncol)];
               end
            end
         end
         default: begin
            y.segment = 6'd1;
         end
      endcase
   endfunction

   function automatic tsl_pkg::req_type make_req(input logic [1:0] op, input int tid,
                                                 input int row, input int col,
                                                 input bit one_d,
                                                 input logic [31:0] value);
      tsl_pkg::req_type r;
      r.op = op;
      r.table_id = 2'(tid);
      r.row = 7'(row);
      r.column = 4'(col);
      r.one_dimensional = one_d;
      r.value = value;
      return r;
   endfunction

   // One transaction: optional idle gap, then hold start until the block takes
   // it. busy is looked at on the falling edge, where it is settled, so the
   // next rising edge is the accepting one.
   task automatic send_item(input tsl_pkg::req_type r);
      tsl_pkg::rsp_type y;
      bit               unwritten;
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_item <= r;
      start <= 1'b1;
      do @(negedge clock); while (busy !== 1'b0);
      @(posedge clock);
      predict_result(r, 1'b1, y, unwritten);
      pending_results.push_back(y);
      items_sent++;
   endtask

   // sender holds off until every outstanding result is back
   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Result checker. The strobe is high for exactly one cycle, so sampling on
   // the falling edge sees each result once, clear of the rising-edge updates.
   always @(negedge clock) begin : check_results
      tsl_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, got status %0d segment %0d",
                     $time, rsp_item.status, rsp_item.segment);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status) begin
               fail_count++;
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_item.status);
            end
            if (rsp_item.previous_value !== want.previous_value) begin
               fail_count++;
               $display("%0t: previous_value expected %0d, got %0d",
                        $time, want.previous_value, rsp_item.previous_value);
            end
            if (rsp_item.next_value !== want.next_value) begin
               fail_count++;
               $display("%0t: next_value expected %0d, got %0d",
                        $time, want.next_value, rsp_item.next_value);
            end
            if (rsp_item.segment !== want.segment) begin
               fail_count++;
               $display("%0t: segment expected %0d, got %0d",
                        $time, want.segment, rsp_item.segment);
            end
         end
      end
   end

   // Fresh out of reset nothing is defined: every lookup reports an undefined
   // table. The unused op code goes through with all fields at their top.
   task automatic test_undefined_tables();
      for (int t = 0; t < NUM_TABLES; t++) begin
         send_item(make_req(tsl_pkg::OP_LOOKUP, t, 1, 2, 1'b1, 32'h0000_0000));
      end
      send_item(make_req(OP_UNUSED, 3, 127, 15, 1'b1, 32'hFFFF_FFFF));
   endtask

   // Shape sizes clamp to 1 and to the maximum; writes outside the maximum rows
   // and columns are dropped; error order: undefined, then not 1D, then bad column.
   task automatic test_shape_clamping();
      send_item(make_req(tsl_pkg::OP_SHAPE, 0, 0, 0, 1'b1, 32'h1234_5678));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 0, 0, 2, 1'b0, 32'h0000_0000));
      send_item(make_req(tsl_pkg::OP_SHAPE, 1, 127, 15, 1'b0, 32'h0000_0000));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 1, 64, 1, 1'b1, 32'h7FFF_FFFF));
      send_item(make_req(tsl_pkg::OP_WRITE, 2, 0, 1, 1'b0, 32'hDEAD_BEEF));
      send_item(make_req(tsl_pkg::OP_WRITE, 2, 127, 0, 1'b1, 32'hDEAD_BEEF));
      send_item(make_req(tsl_pkg::OP_WRITE, 2, 65, 15, 1'b0, 32'hDEAD_BEEF));
   endtask

   // one row table: both values are row 1 of the column, values at the extremes
   task automatic test_one_row_table();
      send_item(make_req(tsl_pkg::OP_SHAPE, 2, 1, 3, 1'b1, 32'h0000_0000));
      send_item(make_req(tsl_pkg::OP_WRITE, 2, 1, 2, 1'b0, 32'h8000_0000));
      send_item(make_req(tsl_pkg::OP_WRITE, 2, 1, 3, 1'b0, 32'h7FFF_FFFF));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 2, 0, 2, 1'b0, 32'h8000_0000));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 2, 0, 3, 1'b0, 32'h7FFF_FFFF));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 2, 0, 4, 1'b0, 32'h0000_0000));
   endtask

   // Four row search: jump to the top segment, back to the bottom, land on
   // an exact abscissa, then flatten one segment so it reports not increasing.
   task automatic test_short_search();
      send_item(make_req(tsl_pkg::OP_SHAPE, 3, 4, 2, 1'b1, 32'h0000_0000));
      send_item(make_req(tsl_pkg::OP_WRITE, 3, 1, 1, 1'b0, 32'h8000_0000));
      send_item(make_req(tsl_pkg::OP_WRITE, 3, 2, 1, 1'b0, 32'hFFFF_FFFB));
      send_item(make_req(tsl_pkg::OP_WRITE, 3, 3, 1, 1'b0, 32'h0000_0007));
      send_item(make_req(tsl_pkg::OP_WRITE, 3, 4, 1, 1'b0, 32'h7FFF_FFFF));
      for (int r = 1; r <= 4; r++) begin
         send_item(make_req(tsl_pkg::OP_WRITE, 3, r, 2, 1'b0, $urandom));
      end
      send_item(make_req(tsl_pkg::OP_LOOKUP, 3, 0, 2, 1'b0, 32'h7FFF_FFFF));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 3, 0, 2, 1'b0, 32'h8000_0000));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 3, 0, 2, 1'b0, 32'h0000_0007));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 3, 0, 2, 1'b0, 32'h0000_0003));
      send_item(make_req(tsl_pkg::OP_WRITE, 3, 3, 1, 1'b0, 32'hFFFF_FFFB));
      send_item(make_req(tsl_pkg::OP_LOOKUP, 3, 0, 2, 1'b0, 32'hFFFF_FFFB));
   endtask

   // Random filler: any op, any field value. Shapes are left to the table
   // sequences, and a lookup that would touch an unwritten cell becomes a write.
   task automatic send_noise();
      tsl_pkg::req_type r;
      tsl_pkg::rsp_type y;
      bit               unwritten;
      r = make_req(2'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom_range(0, 127),
                   $urandom_range(0, 15), 1'($urandom), $urandom);
      if (r.op == tsl_pkg::OP_SHAPE) r.op = OP_UNUSED;
      if (r.op == tsl_pkg::OP_LOOKUP) begin
         predict_result(r, 1'b0, y, unwritten);
         if (unwritten) r.op = tsl_pkg::OP_WRITE;
      end
      send_item(r);
   endtask

   // A well formed sequence: shape a table, fill every cell, then look up
   // abscissas on, next to and between the stored ones.
   task automatic run_table_sequence(input int tid, input int rows, input int cols,
                                     input bit ordered, input int lookups);
      logic signed [31:0] absc [1:MAX_ROWS];
      longint             pos;
      tsl_pkg::req_type   r;
      int                 j;
      int                 k;
      r = make_req(tsl_pkg::OP_SHAPE, tid, rows, cols, $urandom_range(19) != 0, $urandom);
      // out of range sizes that clamp back to the wanted shape
      if (rows == 1 && $urandom_range(1) == 0) r.row = 7'd0;
      if (rows == MAX_ROWS && $urandom_range(1) == 0) r.row = 7'($urandom_range(64, 127));
      if (cols == 1 && $urandom_range(1) == 0) r.column = 4'd0;
      if (cols == MAX_COLS && $urandom_range(1) == 0) r.column = 4'($urandom_range(8, 15));
      send_item(r);

      pos = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF));
      for (int i = 1; i <= rows; i++) begin
         absc[i] = pos[31:0];
         pos += longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
      end
      if ($urandom_range(9) == 0) begin
         absc[1] = 32'h8000_0000;
         if (rows > 1) absc[rows] = 32'h7FFF_FFFF;
      end
      if (!ordered && rows > 1) begin
         if ($urandom_range(1) == 0) begin
            for (int i = 1; i <= rows; i++) absc[i] = $urandom;
         end else begin
            k = $urandom_range(2, rows);
            absc[k] = absc[k - 1] - 32'($urandom_range(0, 3));
         end
      end

      for (int i = 1; i <= rows; i++) begin
         for (int c = 1; c <= cols; c++) begin
            send_item(make_req(tsl_pkg::OP_WRITE, tid, i, c, 1'($urandom),
                               c == 1 ? absc[i] : $urandom));
            if ($urandom_range(19) == 0) send_noise();
         end
      end

      for (int n = 0; n < lookups; n++) begin
         j = $urandom_range(1, rows);
         r = make_req(tsl_pkg::OP_LOOKUP, tid, $urandom_range(0, 127), 0, 1'($urandom),
                      32'h0);
         if ($urandom_range(9) != 0) r.column = 4'($urandom_range(2, cols < 2 ? 2 : cols));
         else r.column = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 5))
            0: r.value = $urandom;
            1, 2: r.value = absc[j];
            3: r.value = absc[j] + 32'sd1;
            4: r.value = absc[j] - 32'sd1;
            default: begin
               if (j < rows) r.value = 32'((longint'(absc[j]) + longint'(absc[j + 1])) >>> 1);
               else r.value = absc[j];
            end
         endcase
         send_item(r);
         if ($urandom_range(9) == 0) send_noise();
      end
   endtask

   // Mostly table sequences with random content, small tables most of the
   // time and a full 64 row one now and then, with noise in between.
   task automatic test_random_traffic();
      int tid;
      int rows;
      int cols;
      int roll;
      int next_pause;
      next_pause = PAUSE_EVERY;
      while (items_sent < ITEM_TARGET) begin
         // long stretch without any idle cycle
         idle_on = !(items_sent >= 300 && items_sent < 700);
         if (items_sent >= next_pause) begin
            wait_all_results();
            next_pause += PAUSE_EVERY;
         end
         if ($urandom_range(9) == 0) begin
            // stray shape, any size: that table may hold unwritten cells afterwards
            send_item(make_req(tsl_pkg::OP_SHAPE, $urandom_range(0, 3),
                               $urandom_range(0, 127), $urandom_range(0, 15),
                               1'($urandom), $urandom));
         end
         tid = $urandom_range(0, 3);
         roll = $urandom_range(99);
         if (roll < 15) rows = 1;
         else if (roll < 80) rows = $urandom_range(2, 8);
         else if (roll < 95) rows = $urandom_range(9, 32);
         else rows = MAX_ROWS;
         if (rows >= 32) cols = $urandom_range(2, 3);
         else if ($urandom_range(9) == 0) cols = 1;
         else cols = $urandom_range(2, MAX_COLS);
         run_table_sequence(tid, rows, cols, $urandom_range(9) != 0,
                            rows >= 32 ? 24 : $urandom_range(3, 10));
         repeat ($urandom_range(0, 3)) send_noise();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      fail_count = 0;
      items_sent = 0;
      idle_on = 1'b1;
      for (int t = 0; t < NUM_TABLES; t++) begin
         tbl_rows[t] = 1;
         tbl_cols[t] = 1;
         tbl_one_d[t] = 1'b0;
         tbl_defined[t] = 1'b0;
         hint_seg[t] = 1;
      end
      for (int i = 0; i < STORE_DEPTH; i++) elem_written[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_undefined_tables();
      test_shape_clamping();
      test_one_row_table();
      test_short_search();
      wait_all_results();
      test_random_traffic();

      // drain the outstanding results
      start <= 1'b0;
      for (int n = 0; n < 4000 && pending_results.size() != 0; n++) @(posedge clock);
      if (pending_results.size() != 0) begin
         fail_count += pending_results.size();
         $display("%0t: %0d results expected, none received",
                  $time, pending_results.size());
      end
      repeat (2 * MAX_ROWS + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("table_step_lookup_core test passed");
      end else begin
         $display("table_step_lookup_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/tsl_pkg.sv
rtl/core/tsl_ram.sv
rtl/core/tsl_ctrl.sv
rtl/core/tsl_datapath.sv
rtl/core/table_step_lookup_core.sv
rtl/core/tsl_checker.sv
test/tb_table_step_lookup_core.sv
